// ===== design/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the spline segment tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

	localparam int MAX_POINTS = 64;   // curve points per segment, upper bound
	localparam int N_W        = 6;    // subdivision count width
	localparam int SMOOTH_W   = 16;   // smoothness, unsigned Q0.16
	localparam int NN_W       = 12;   // n*n, m*m, i*i
	localparam int DEN_W      = 18;   // n^3 and the cubic weights
	localparam int D2_W       = 19;   // divisor 2*n^3
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHNESS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SEGMENTS = 1'b1;

	localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 16'd6554;
	localparam logic [N_W-1:0]      NSEG_RST   = 6'd16;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP      = 5'd0;
	localparam op_t OP_LOAD     = 5'd1;
	localparam op_t OP_CP0      = 5'd2;
	localparam op_t OP_CP1      = 5'd3;
	localparam op_t OP_CP2      = 5'd4;
	localparam op_t OP_CP3      = 5'd5;
	localparam op_t OP_NN       = 5'd6;
	localparam op_t OP_DEN      = 5'd7;
	localparam op_t OP_MM       = 5'd8;
	localparam op_t OP_II       = 5'd9;
	localparam op_t OP_W0       = 5'd10;
	localparam op_t OP_W1       = 5'd11;
	localparam op_t OP_W2       = 5'd12;
	localparam op_t OP_W3       = 5'd13;
	localparam op_t OP_X0       = 5'd14;
	localparam op_t OP_X1       = 5'd15;
	localparam op_t OP_X2       = 5'd16;
	localparam op_t OP_X3       = 5'd17;
	localparam op_t OP_Y0       = 5'd18;
	localparam op_t OP_Y1       = 5'd19;
	localparam op_t OP_Y2       = 5'd20;
	localparam op_t OP_Y3       = 5'd21;
	localparam op_t OP_DIV_LDX  = 5'd22;
	localparam op_t OP_DIV_LDY  = 5'd23;
	localparam op_t OP_DIV_STEP = 5'd24;
	localparam op_t OP_EMIT     = 5'd25;

	typedef struct packed {
		logic last;   // current point index equals n
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: issues one datapath op per cycle and owns the beat handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl
	import sst_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_valid,
	input  wire logic       m_ready,
	input  wire dp_status_t status,
	output logic            s_ready,
	output logic            m_valid,
	output op_t             op
);

	localparam int QB   = COORD_WIDTH + 3;
	localparam int CNTW = $clog2(COORD_WIDTH + 4);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_POINT = 3'd2;
	localparam logic [2:0] ST_DIVX  = 3'd3;
	localparam logic [2:0] ST_DIVY  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]      state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic            out_valid_q, out_valid_d;
	logic            emit_ok;

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = out_valid_q;
	assign emit_ok = !out_valid_q || m_ready;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q + CNTW'(1);
		op          = OP_NOP;
		out_valid_d = out_valid_q && !m_ready;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (s_valid) begin
					op      = OP_LOAD;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				unique case (cnt_q)
					CNTW'(0): op = OP_CP0;
					CNTW'(1): op = OP_CP1;
					CNTW'(2): op = OP_CP2;
					CNTW'(3): op = OP_CP3;
					CNTW'(4): op = OP_NN;
					CNTW'(6): op = OP_DEN;
					default:  op = OP_NOP;
				endcase
				if (cnt_q == CNTW'(6)) begin
					state_d = ST_POINT;
					cnt_d   = '0;
				end
			end
			ST_POINT: begin
				unique case (cnt_q)
					CNTW'(0):  op = OP_MM;
					CNTW'(1):  op = OP_II;
					CNTW'(2):  op = OP_W0;
					CNTW'(3):  op = OP_W1;
					CNTW'(4):  op = OP_W2;
					CNTW'(5):  op = OP_W3;
					CNTW'(6):  op = OP_X0;
					CNTW'(7):  op = OP_X1;
					CNTW'(8):  op = OP_X2;
					CNTW'(9):  op = OP_X3;
					CNTW'(10): op = OP_Y0;
					CNTW'(11): op = OP_Y1;
					CNTW'(12): op = OP_Y2;
					CNTW'(13): op = OP_Y3;
					default:   op = OP_NOP;
				endcase
				if (cnt_q == CNTW'(13)) begin
					state_d = ST_DIVX;
					cnt_d   = '0;
				end
			end
			ST_DIVX: begin
				op = (cnt_q == '0) ? OP_DIV_LDX : OP_DIV_STEP;
				if (cnt_q == CNTW'(QB)) begin
					state_d = ST_DIVY;
					cnt_d   = '0;
				end
			end
			ST_DIVY: begin
				op = (cnt_q == '0) ? OP_DIV_LDY : OP_DIV_STEP;
				if (cnt_q == CNTW'(QB)) begin
					state_d = ST_EMIT;
					cnt_d   = '0;
				end
			end
			ST_EMIT: begin
				cnt_d = '0;
				if (emit_ok) begin
					op          = OP_EMIT;
					out_valid_d = 1'b1;
					state_d     = status.last ? ST_IDLE : ST_POINT;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/sst_dpath.sv =====
// ----------------------------------------------------------------------------
// sst_dpath
// Datapath: shared multiplier, accumulators, bit-serial divider, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_dpath
	import sst_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire op_t                           op,
	output dp_status_t                         status,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic signed [COORD_WIDTH-1:0] prev_x,
	input  wire logic signed [COORD_WIDTH-1:0] prev_y,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	input  wire logic signed [COORD_WIDTH-1:0] next_x,
	input  wire logic signed [COORD_WIDTH-1:0] next_y,
	input  wire logic                          has_prev,
	input  wire logic                          has_next,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output logic [N_W-1:0]                     point_index,
	output logic                               point_last
);

	localparam int CW   = COORD_WIDTH;
	localparam int CPW  = CW + 2;        // control points
	localparam int DFW  = CW + 3;        // neighbour differences
	localparam int AW   = CW + 4;        // multiplier operand A
	localparam int BW   = 20;            // multiplier operand B
	localparam int PW   = AW + BW;
	localparam int SW   = PW - 15;       // control point sum before clamp
	localparam int NUMW = CW + 20;       // curve numerator
	localparam int QB   = CW + 3;        // quotient bits
	localparam int NW   = QB + D2_W;     // offset dividend

	localparam logic [N_W-1:0] N_MAX = N_W'(MAX_POINTS - 1);

	function automatic logic [CPW-1:0] sat_cp(input logic [SW-1:0] v);
		if (v[SW-1:CPW-1] == {(SW-CPW+1){v[SW-1]}})
			return v[CPW-1:0];
		return v[SW-1] ? {1'b1, {(CPW-1){1'b0}}} : {1'b0, {(CPW-1){1'b1}}};
	endfunction

	function automatic logic [CW-1:0] sat_out(input logic [QB-1:0] v);
		if (v[QB-1:CW-1] == {(QB-CW+1){v[QB-1]}})
			return v[CW-1:0];
		return v[QB-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	// configuration
	logic [SMOOTH_W-1:0] smooth_q;
	logic [N_W-1:0]      nseg_q;

	// per segment
	logic signed [CPW-1:0] sx_q, sy_q, ex_q, ey_q, c1x_q, c1y_q, c2x_q, c2y_q;
	logic signed [DFW-1:0] dx1_q, dy1_q, dx2_q, dy2_q;
	logic [SMOOTH_W-1:0]   s_q;
	logic [N_W-1:0]        n_q, i_q;
	logic [NN_W-1:0]       nn_q, mm_q, ii_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      w_q [4];
	logic signed [NUMW-1:0] accx_q, accy_q;

	// multiplier
	op_t                  op_q;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod_q;

	// divider
	logic [D2_W-1:0] rem_q;
	logic [QB-1:0]   dvd_q, qx_q;

	// output register
	logic [CW-1:0]  ox_q, oy_q;
	logic [N_W-1:0] oidx_q;
	logic           olast_q;

	logic [N_W-1:0] m_val, n_clamp;
	logic [7:0]     three_i, three_m;

	logic signed [CPW-1:0] ld_sx, ld_sy, ld_ex, ld_ey, ld_px, ld_py, ld_nx, ld_ny;

	logic signed [PW-16-1:0] cp_off;
	logic signed [CPW-1:0]   cp_anchor;
	logic [CPW-1:0]          cp_res;

	logic signed [NUMW-1:0] div_acc;
	logic [NW-1:0]          div_a;
	logic [D2_W-1:0]        d2;
	logic [D2_W:0]          div_t;
	logic                   div_ge;

	assign m_val       = n_q - i_q;
	assign three_i     = 8'(i_q) + 8'({i_q, 1'b0});
	assign three_m     = 8'(m_val) + 8'({m_val, 1'b0});
	assign status.last = (i_q == n_q);

	assign n_clamp = (nseg_q == '0) ? N_W'(1) : ((nseg_q > N_MAX) ? N_MAX : nseg_q);

	// reflected neighbours stay exact in CPW bits
	assign ld_sx = CPW'(start_x);
	assign ld_sy = CPW'(start_y);
	assign ld_ex = CPW'(end_x);
	assign ld_ey = CPW'(end_y);
	assign ld_px = has_prev ? CPW'(prev_x) : (ld_sx <<< 1) - ld_ex;
	assign ld_py = has_prev ? CPW'(prev_y) : (ld_sy <<< 1) - ld_ey;
	assign ld_nx = has_next ? CPW'(next_x) : (ld_ex <<< 1) - ld_sx;
	assign ld_ny = has_next ? CPW'(next_y) : (ld_ey <<< 1) - ld_sy;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_CP0: begin mul_a = AW'(dx1_q); mul_b = BW'(s_q); end
			OP_CP1: begin mul_a = AW'(dy1_q); mul_b = BW'(s_q); end
			OP_CP2: begin mul_a = AW'(dx2_q); mul_b = BW'(s_q); end
			OP_CP3: begin mul_a = AW'(dy2_q); mul_b = BW'(s_q); end
			OP_NN:  begin mul_a = AW'(n_q);   mul_b = BW'(n_q); end
			OP_DEN: begin mul_a = AW'(nn_q);  mul_b = BW'(n_q); end
			OP_MM:  begin mul_a = AW'(m_val); mul_b = BW'(m_val); end
			OP_II:  begin mul_a = AW'(i_q);   mul_b = BW'(i_q); end
			OP_W0:  begin mul_a = AW'(mm_q);  mul_b = BW'(m_val); end
			OP_W1:  begin mul_a = AW'(mm_q);  mul_b = BW'(three_i); end
			OP_W2:  begin mul_a = AW'(ii_q);  mul_b = BW'(three_m); end
			OP_W3:  begin mul_a = AW'(ii_q);  mul_b = BW'(i_q); end
			OP_X0:  begin mul_a = AW'(sx_q);  mul_b = BW'(w_q[0]); end
			OP_X1:  begin mul_a = AW'(c1x_q); mul_b = BW'(w_q[1]); end
			OP_X2:  begin mul_a = AW'(c2x_q); mul_b = BW'(w_q[2]); end
			OP_X3:  begin mul_a = AW'(ex_q);  mul_b = BW'(w_q[3]); end
			OP_Y0:  begin mul_a = AW'(sy_q);  mul_b = BW'(w_q[0]); end
			OP_Y1:  begin mul_a = AW'(c1y_q); mul_b = BW'(w_q[1]); end
			OP_Y2:  begin mul_a = AW'(c2y_q); mul_b = BW'(w_q[2]); end
			OP_Y3:  begin mul_a = AW'(ey_q);  mul_b = BW'(w_q[3]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// control point: anchor + round(s*d / 2^16), halves up, clamped
	always_comb begin
		unique case (op_q)
			OP_CP0:  cp_anchor = sx_q;
			OP_CP1:  cp_anchor = sy_q;
			OP_CP2:  cp_anchor = ex_q;
			default: cp_anchor = ey_q;
		endcase
		cp_off = (PW-16)'((prod_q + $signed(PW'(32768))) >>> 16);
		cp_res = sat_cp(SW'(cp_anchor) + SW'(cp_off));
	end

	// offset dividend (2*num + den) + den*2^QB keeps the division unsigned
	assign d2      = {den_q, 1'b0};
	assign div_acc = (op == OP_DIV_LDX) ? accx_q : accy_q;
	assign div_a   = (NW'(div_acc) << 1) + NW'(den_q) + NW'({den_q, {QB{1'b0}}});
	assign div_t   = {rem_q, dvd_q[QB-1]};
	assign div_ge  = (div_t >= {1'b0, d2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= SMOOTH_RST;
			nseg_q   <= NSEG_RST;
			i_q      <= '0;
			op_q     <= OP_NOP;
		end else begin
			op_q <= op;
			if (cfg_we) begin
				if (cfg_index == REG_SMOOTHNESS)
					smooth_q <= cfg_data[SMOOTH_W-1:0];
				else if (cfg_index == REG_NUM_SEGMENTS)
					nseg_q <= cfg_data[N_W-1:0];
			end
			if (op == OP_LOAD)
				i_q <= '0;
			else if (op == OP_EMIT)
				i_q <= status.last ? '0 : i_q + N_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (op_q)
			OP_CP0: c1x_q  <= cp_res;
			OP_CP1: c1y_q  <= cp_res;
			OP_CP2: c2x_q  <= cp_res;
			OP_CP3: c2y_q  <= cp_res;
			OP_NN:  nn_q   <= prod_q[NN_W-1:0];
			OP_DEN: den_q  <= prod_q[DEN_W-1:0];
			OP_MM:  mm_q   <= prod_q[NN_W-1:0];
			OP_II:  ii_q   <= prod_q[NN_W-1:0];
			OP_W0:  w_q[0] <= prod_q[DEN_W-1:0];
			OP_W1:  w_q[1] <= prod_q[DEN_W-1:0];
			OP_W2:  w_q[2] <= prod_q[DEN_W-1:0];
			OP_W3:  w_q[3] <= prod_q[DEN_W-1:0];
			OP_X0:  accx_q <= prod_q[NUMW-1:0];
			OP_X1, OP_X2, OP_X3: accx_q <= accx_q + $signed(prod_q[NUMW-1:0]);
			OP_Y0:  accy_q <= prod_q[NUMW-1:0];
			OP_Y1, OP_Y2, OP_Y3: accy_q <= accy_q + $signed(prod_q[NUMW-1:0]);
			default: ;
		endcase

		unique case (op)
			OP_LOAD: begin
				sx_q  <= ld_sx;
				sy_q  <= ld_sy;
				ex_q  <= ld_ex;
				ey_q  <= ld_ey;
				dx1_q <= DFW'(ld_ex) - DFW'(ld_px);
				dy1_q <= DFW'(ld_ey) - DFW'(ld_py);
				dx2_q <= DFW'(ld_sx) - DFW'(ld_nx);
				dy2_q <= DFW'(ld_sy) - DFW'(ld_ny);
				s_q   <= smooth_q;
				n_q   <= n_clamp;
			end
			OP_DIV_LDX: begin
				rem_q <= div_a[NW-1:QB];
				dvd_q <= div_a[QB-1:0];
			end
			OP_DIV_LDY: begin
				qx_q  <= dvd_q;
				rem_q <= div_a[NW-1:QB];
				dvd_q <= div_a[QB-1:0];
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? D2_W'(div_t - {1'b0, d2}) : div_t[D2_W-1:0];
				dvd_q <= {dvd_q[QB-2:0], div_ge};
			end
			OP_EMIT: begin
				// undo the offset by flipping the quotient MSB
				ox_q    <= sat_out({~qx_q[QB-1], qx_q[QB-2:0]});
				oy_q    <= sat_out({~dvd_q[QB-1], dvd_q[QB-2:0]});
				oidx_q  <= i_q;
				olast_q <= status.last;
			end
			default: ;
		endcase
	end

	assign point_x     = ox_q;
	assign point_y     = oy_q;
	assign point_index = oidx_q;
	assign point_last  = olast_q;

endmodule

`default_nettype wire

// ===== design/smooth_spline_segment_tessellator_core.sv =====
// ----------------------------------------------------------------------------
// smooth_spline_segment_tessellator_core
// Turns one polyline segment into the points of a smoothed cubic curve.
// ----------------------------------------------------------------------------
// Input stream: one beat per segment, prev/start/end/next points in tdata and
// the has_prev/has_next flags in tuser. A missing neighbour is reflected from
// the opposite anchor. Output stream: one beat per curve point, n+1 beats per
// segment (n = num_segments, 0 read as 1), tlast on the final point.
// Sequence: the input beat is taken in idle; set-up steps then form the two
// control points and n^3. Every point takes the multiply steps for its
// weights and coordinate products, two bit-serial divisions (x, then y)
// and the emit step. One shared multiplier and one restoring divider do
// this work in turn. s_tready is high only between segments, so no new
// segment is taken before the last point of the current one is emitted.
// The last point sits in the output register while the next segment is
// accepted. When the receiver stalls, the point holds in the output register
// and the sequencer waits before overwriting it.
// Reset (arst_n low) empties the output register, returns to idle and loads
// smoothness = 6554 and num_segments = 16. Configuration writes are taken
// when cfg_we is high and should only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_spline_segment_tessellator_core
	import sst_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	localparam int OUT_TDW = ((2 * COORD_WIDTH + N_W + 7) / 8) * 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// prev_x, prev_y, start_x, start_y, end_x, end_y, next_x, next_y
	input  wire logic [8*COORD_WIDTH-1:0] s_tdata,
	// has_prev, has_next
	input  wire logic [1:0]               s_tuser,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, point_index, zero pad
	output logic [OUT_TDW-1:0]            m_tdata,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = COORD_WIDTH;

	op_t        op;
	dp_status_t status;

	logic signed [CW-1:0] point_x, point_y;
	logic [N_W-1:0]       point_index;

	sst_ctrl #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.m_ready (m_tready),
		.status  (status),
		.s_ready (s_tready),
		.m_valid (m_tvalid),
		.op      (op)
	);

	sst_dpath #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.prev_x      (s_tdata[0*CW +: CW]),
		.prev_y      (s_tdata[1*CW +: CW]),
		.start_x     (s_tdata[2*CW +: CW]),
		.start_y     (s_tdata[3*CW +: CW]),
		.end_x       (s_tdata[4*CW +: CW]),
		.end_y       (s_tdata[5*CW +: CW]),
		.next_x      (s_tdata[6*CW +: CW]),
		.next_y      (s_tdata[7*CW +: CW]),
		.has_prev    (s_tuser[0]),
		.has_next    (s_tuser[1]),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.point_last  (m_tlast)
	);

	assign m_tdata = OUT_TDW'({point_index, point_y, point_x});

endmodule

`default_nettype wire

// ===== design/sst_checker.sv =====
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_checker
	import sst_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	localparam int OUT_TDW = ((2 * COORD_WIDTH + N_W + 7) / 8) * 8
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic [OUT_TDW-1:0]       m_tdata,
	input wire logic                     m_tlast,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready
);

	// a held output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// a held output beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// one segment at a time: busy right after taking a segment
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// no new segment while a mid-segment point is handed over
	a_no_in_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> !s_tready)
		else $error("ready for a new segment before the last point");

endmodule

bind smooth_spline_segment_tessellator_core sst_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_sst_checker (.*);

`default_nettype wire

// ===== sim/smooth_spline_segment_tessellator_core_tb.sv =====
// ----------------------------------------------------------------------------
// smooth_spline_segment_tessellator_core_tb
// Self-checking bench for the spline segment tessellator: segments go in on
// the slave stream, every curve point is predicted and checked on the master
// stream, across several smoothness and subdivision settings.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_spline_segment_tessellator_core_tb;
	import sst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW      = 16;
	localparam int OUT_TDW = ((2 * CW + N_W + 7) / 8) * 8;
	localparam longint CYCLE_LIMIT = 64'd10_000_000;

	// one segment as offered on the slave stream
	typedef struct {
		logic [8*CW-1:0] pts;   // prev_x, prev_y, start_x, start_y, end_x, end_y, next_x, next_y
		logic [1:0]      flags; // has_prev, has_next
	} segment_t;

	// one curve point as expected on the master stream
	typedef struct {
		logic [CW-1:0]  px;
		logic [CW-1:0]  py;
		logic [N_W-1:0] idx;
		logic           last;
	} curve_point_t;

	logic clk;
	logic arst_n;
	logic [8*CW-1:0]       s_tdata;
	logic [1:0]            s_tuser;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [OUT_TDW-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	smooth_spline_segment_tessellator_core #(.COORD_WIDTH(CW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor's own copy of the registers
	longint smooth_q16;
	longint nseg_reg;

	segment_t     pending_segs[$];
	curve_point_t expected_points[$];
	int  fail_count = 0;
	bit  calm;        // no idling in the final stretch
	bit  hold_off;    // long receiver stall request
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q -= 1;
		return q;
	endfunction

	function automatic longint clamp_signed(longint v, int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint tangent_point(longint anchor, longint diff);
		return clamp_signed(anchor + fdiv(smooth_q16 * diff + 32768, 65536), CW + 2);
	endfunction

	// expands one segment into its curve points on the expectation queue
	task automatic tessellate(segment_t seg);
		longint c[8];   // start, C1, C2, end (x, y interleaved)
		longint pt[8];
		longint n, den, m, w0, w1, w2, w3, num, v;
		curve_point_t cp;
		for (int k = 0; k < 8; k++)
			pt[k] = longint'($signed(seg.pts[k*CW +: CW]));
		if (!seg.flags[0]) begin
			pt[0] = 2 * pt[2] - pt[4];
			pt[1] = 2 * pt[3] - pt[5];
		end
		if (!seg.flags[1]) begin
			pt[6] = 2 * pt[4] - pt[2];
			pt[7] = 2 * pt[5] - pt[3];
		end
		n = nseg_reg;
		if (n < 1) n = 1;
		if (n > MAX_POINTS - 1) n = MAX_POINTS - 1;
		c[0] = pt[2];
		c[1] = pt[3];
		c[2] = tangent_point(pt[2], pt[4] - pt[0]);
		c[3] = tangent_point(pt[3], pt[5] - pt[1]);
		c[4] = tangent_point(pt[4], -(pt[6] - pt[2]));
		c[5] = tangent_point(pt[5], -(pt[7] - pt[3]));
		c[6] = pt[4];
		c[7] = pt[5];
		den = n * n * n;
		for (longint i = 0; i <= n; i++) begin
			m  = n - i;
			w0 = m * m * m;
			w1 = 3 * m * m * i;
			w2 = 3 * m * i * i;
			w3 = i * i * i;
			for (int a = 0; a < 2; a++) begin
				num = c[a] * w0 + c[2+a] * w1 + c[4+a] * w2 + c[6+a] * w3;
				v = clamp_signed(fdiv(2 * num + den, 2 * den), CW);
				if (a == 0) cp.px = v[CW-1:0];
				else        cp.py = v[CW-1:0];
			end
			cp.idx  = i[N_W-1:0];
			cp.last = (i == n);
			expected_points.insert(expected_points.size(), cp);
		end
	endtask

	// -------------------------------------------------------------- driver
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			src_gap  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tessellate(pending_segs.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(1, 18);
					s_tvalid <= 1'b0;
				end else if (pending_segs.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_segs[0].pts;
					s_tuser  <= pending_segs[0].flags;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------- monitor
	int sink_gap;
	always @(posedge clk or negedge arst_n) begin
		curve_point_t exp_pt;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected point beat: tdata=%h", m_tdata);
					fail_count++;
				end else begin
					exp_pt = expected_points.pop_front();
					if (m_tdata[0 +: CW] !== exp_pt.px) begin
						$error("point_x expected %h got %h", exp_pt.px, m_tdata[0 +: CW]);
						fail_count++;
					end
					if (m_tdata[CW +: CW] !== exp_pt.py) begin
						$error("point_y expected %h got %h", exp_pt.py, m_tdata[CW +: CW]);
						fail_count++;
					end
					if (m_tdata[2*CW +: N_W] !== exp_pt.idx) begin
						$error("point_index expected %0d got %0d", exp_pt.idx,
							m_tdata[2*CW +: N_W]);
						fail_count++;
					end
					if (m_tlast !== exp_pt.last) begin
						$error("point_last expected %b got %b", exp_pt.last, m_tlast);
						fail_count++;
					end
				end
			end
			// receiver stall: long hold-off, random bursts, or ready
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(1, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ----------------------------------------------------------- stimulus
	function automatic segment_t rand_segment(int span);
		segment_t seg;
		for (int k = 0; k < 8; k++) begin
			case (span)
				0:       seg.pts[k*CW +: CW] = CW'($urandom());
				1:       seg.pts[k*CW +: CW] = CW'($urandom_range(0, 4095) - 2048);
				default: seg.pts[k*CW +: CW] = CW'(($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
						^ $urandom_range(0, 3));
			endcase
		end
		seg.flags = 2'($urandom());
		return seg;
	endfunction

	function automatic segment_t fill_segment(logic [CW-1:0] v, logic [1:0] f);
		segment_t seg;
		seg.pts   = {8{v}};
		seg.flags = f;
		return seg;
	endfunction

	task automatic queue_seg(segment_t seg);
		pending_segs.insert(pending_segs.size(), seg);
	endtask

	task automatic drain();
		while (pending_segs.size() > 0 || expected_points.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_SMOOTHNESS) smooth_q16 = val;
		else                       nseg_reg   = val & 16'h3F;
		@(posedge clk);
	endtask

	initial begin
		segment_t seg;
		bit       missing;
		calm        = 1'b0;
		hold_off    = 1'b0;
		smooth_q16  = SMOOTH_RST;
		nseg_reg    = NSEG_RST;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extreme coordinates and every flag pair
		queue_seg(fill_segment(16'h0000, 2'b11));
		queue_seg(fill_segment(16'h7FFF, 2'b00));
		queue_seg(fill_segment(16'h8000, 2'b00));
		seg.pts = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
			16'h7FFF};
		for (int f = 0; f < 4; f++) begin
			seg.flags = 2'(f);
			queue_seg(seg);
		end
		seg.pts = ~seg.pts;
		seg.flags = 2'b00;
		queue_seg(seg);
		for (int k = 0; k < 4; k++) queue_seg(rand_segment(2));
		drain();

		// zero subdivisions read as one, full smoothness
		write_reg(REG_NUM_SEGMENTS, 16'd0);
		write_reg(REG_SMOOTHNESS, 16'hFFFF);
		for (int k = 0; k < 5; k++) queue_seg(rand_segment(k % 3));
		drain();

		// largest N, zero smoothness
		write_reg(REG_NUM_SEGMENTS, 16'd63);
		write_reg(REG_SMOOTHNESS, 16'd0);
		queue_seg(rand_segment(2));
		queue_seg(rand_segment(0));
		drain();

		// long receiver stall while the sender keeps offering
		write_reg(REG_NUM_SEGMENTS, 16'd3);
		hold_off = 1'b1;
		for (int k = 0; k < 4; k++) queue_seg(rand_segment(0));
		repeat (2000) @(posedge clk);
		hold_off = 1'b0;
		drain();

		// random phases, mostly small N
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_SMOOTHNESS, CFG_DATA_W'($urandom()));
			write_reg(REG_NUM_SEGMENTS, CFG_DATA_W'((ph == 5) ? $urandom_range(40, 63)
				: $urandom_range(0, 8)));
			if (ph == 5) calm = 1'b1;
			for (int k = 0; k < ((ph == 5) ? 8 : 43); k++)
				queue_seg(rand_segment($urandom_range(0, 2)));
			drain();
		end

		missing = (expected_points.size() != 0);
		if (missing)
			$error("%0d points never arrived", expected_points.size());
		if (fail_count == 0 && !missing) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
